// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the line mover.
// Depends on nothing; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/core/smlm_pkg.sv =====
// Types, codes and sizes shared by the stepper line mover.
// No dependencies.
package smlm_pkg;

  localparam int PosBits     = 16;
  localparam int InDataBits  = ((2 * PosBits + 7) / 8) * 8;
  localparam int OutDataBits = 8;
  localparam int CfgIdxBits  = 2;
  localparam int QDepth      = 2;
  localparam int QPtrBits    = $clog2(QDepth);
  localparam int QCntBits    = $clog2(QDepth + 1);
  localparam int DivCntBits  = $clog2(PosBits + 1);

  localparam logic [CfgIdxBits-1:0] CFG_MAX_X = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_MAX_Y = CfgIdxBits'(1);

  typedef logic [PosBits-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_LINE   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_TICK = 2'd0,
    ST_ACK  = 2'd1,
    ST_NACK = 2'd2,
    ST_BUSY = 2'd3
  } status_t;

  typedef struct packed {
    kind_t kind;
    pos_t  tx;
    pos_t  ty;
  } cmd_t;

  typedef struct packed {
    logic ydir;
    logic xdir;
    logic yen;
    logic xen;
    logic xmaj;
  } flags_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic dividing;
    logic moving;
  } bk_status_t;

endpackage

// ===== rtl/core/two_axis_stepper_line_mover_unit.sv =====
// Top level of the two-axis stepper line mover: front end, queue, back end.
// Depends on smlm_pkg, smlm_front, smlm_queue, smlm_back and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  s_axis  | in  | s_tvalid/s_tready  | tdata: target_x, target_y; tuser: kind
//  m_axis  | out | m_tvalid/m_tready  | tdata: step/dir/pen/done; tuser: status
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (max_x, max_y)
//
// Ticks and commands needing no ratio give one result per cycle unless the output
// stalls or the restoring divider runs, as it does for a command moving both axes.
// Reset is synchronous; no clearing pass follows.
// A two-entry queue and the output register let input and output stall apart.
`include "assert_macros.svh"
module two_axis_stepper_line_mover_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: target_x, target_y
  input  logic [smlm_pkg::InDataBits-1:0]  s_tdata,
  // s_tuser: kind
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: x_step, x_dir, y_step, y_dir, pen_is_up, move_done, two zero bits
  output logic [smlm_pkg::OutDataBits-1:0] m_tdata,
  // m_tuser: status
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smlm_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data
);

  smlm_pkg::q_status_t  q_stat;
  smlm_pkg::bk_status_t bk_stat;
  smlm_pkg::cmd_t       wr_entry;
  smlm_pkg::cmd_t       rd_entry;
  logic                 q_push;
  logic                 q_pop;

  smlm_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  smlm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  smlm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_entry   (rd_entry),
    .q_pop     (q_pop),
    .bk_stat   (bk_stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  `ASSERT_IMPLIES(a_cmd_no_step, clk, rst, m_tvalid && (m_tuser != smlm_pkg::ST_TICK), (m_tdata[0] == 1'b0) && (m_tdata[2] == 1'b0) && (m_tdata[5] == 1'b0), "command result carries a step or done")
  `ASSERT_IMPLIES(a_no_pop_div, clk, rst, bk_stat.dividing, !q_pop, "queue popped while dividing")
  `ASSERT_IMPLIES(a_full_stall, clk, rst, q_stat.full, !s_tready && !q_push, "push into a full queue")
  `ASSERT_NEXT(a_div_moving, clk, rst, bk_stat.dividing, bk_stat.moving, "ratio pending without a move")

endmodule

// ===== rtl/core/smlm_front.sv =====
// Front end: takes input beats, decodes the kind and resolves the target.
// Depends on smlm_pkg.
module smlm_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [smlm_pkg::InDataBits-1:0] s_tdata,
  input  logic [1:0]                      s_tuser,
  input  smlm_pkg::q_status_t             q_stat,
  output logic                            q_push,
  output smlm_pkg::cmd_t                  q_entry
);

  smlm_pkg::kind_t kind;

  assign kind     = smlm_pkg::kind_t'(s_tuser);
  assign s_tready = !q_stat.full;
  assign q_push   = s_tvalid && !q_stat.full;

  always_comb begin
    q_entry.kind = kind;
    q_entry.tx   = s_tdata[smlm_pkg::PosBits-1:0];
    q_entry.ty   = s_tdata[2*smlm_pkg::PosBits-1:smlm_pkg::PosBits];
    if (kind == smlm_pkg::KIND_FINISH) begin
      q_entry.tx = '0;
      q_entry.ty = '0;
    end
  end

endmodule

// ===== rtl/core/smlm_queue.sv =====
// Short command queue between front and back end.
// Depends on smlm_pkg.
module smlm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  smlm_pkg::cmd_t      wr_entry,
  input  logic                pop,
  output smlm_pkg::cmd_t      rd_entry,
  output smlm_pkg::q_status_t stat
);

  smlm_pkg::cmd_t                mem [smlm_pkg::QDepth];
  logic [smlm_pkg::QPtrBits-1:0] wr_ptr;
  logic [smlm_pkg::QPtrBits-1:0] rd_ptr;
  logic [smlm_pkg::QCntBits-1:0] count;

  localparam logic [smlm_pkg::QPtrBits-1:0] LastPtr = smlm_pkg::QPtrBits'(smlm_pkg::QDepth - 1);

  assign rd_entry   = mem[rd_ptr];
  assign stat.full  = (count == smlm_pkg::QCntBits'(smlm_pkg::QDepth));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/smlm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the minor axis ratio.
// Depends on smlm_pkg.
module smlm_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  smlm_pkg::pos_t dividend,
  input  smlm_pkg::pos_t divisor,
  output logic           done,
  output smlm_pkg::pos_t quotient
);

  smlm_pkg::pos_t                  rem;
  smlm_pkg::pos_t                  quo;
  smlm_pkg::pos_t                  dsr;
  logic [smlm_pkg::DivCntBits-1:0] cnt;
  logic                            running;
  logic [smlm_pkg::PosBits:0]      partial;
  logic [smlm_pkg::PosBits:0]      diff;
  logic                            ge;

  assign partial  = {rem, quo[smlm_pkg::PosBits-1]};
  assign diff     = partial - {1'b0, dsr};
  assign ge       = (partial >= {1'b0, dsr});
  assign done     = !running;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      quo <= {quo[smlm_pkg::PosBits-2:0], ge};
      rem <= ge ? diff[smlm_pkg::PosBits-1:0] : partial[smlm_pkg::PosBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= smlm_pkg::DivCntBits'(smlm_pkg::PosBits);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == smlm_pkg::DivCntBits'(1)) begin
        running <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/smlm_back.sv =====
// Back end: position state, move loading, step generation and result register.
// Depends on smlm_pkg and smlm_div.
module smlm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smlm_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data,
  input  smlm_pkg::q_status_t              q_stat,
  input  smlm_pkg::cmd_t                   q_entry,
  output logic                             q_pop,
  output smlm_pkg::bk_status_t             bk_stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [smlm_pkg::OutDataBits-1:0] m_tdata,
  output logic [1:0]                       m_tuser
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t           state;
  smlm_pkg::pos_t   max_x;
  smlm_pkg::pos_t   max_y;
  smlm_pkg::pos_t   position_x;
  smlm_pkg::pos_t   position_y;
  smlm_pkg::pos_t   goal_x;
  smlm_pkg::pos_t   goal_y;
  smlm_pkg::pos_t   steps_left;
  smlm_pkg::pos_t   minor_ratio;
  smlm_pkg::pos_t   ratio_count;
  smlm_pkg::flags_t flags;
  logic             pen_up;
  logic             busy;

  smlm_pkg::status_t out_status;
  logic              out_xs;
  logic              out_ys;
  logic              out_done;
  smlm_pkg::flags_t  out_fl;
  logic              out_pen;

  logic             slot_free;
  logic             take;
  logic             is_tick;
  smlm_pkg::pos_t   rc_inc;
  logic             hit;
  logic             major_en;
  logic             minor_en;
  logic             tick_xs;
  logic             tick_ys;
  smlm_pkg::pos_t   sl_dec;
  logic             last;
  logic             pen_new;
  logic             in_range;
  smlm_pkg::flags_t n_fl;
  smlm_pkg::pos_t   dx;
  smlm_pkg::pos_t   dy;
  smlm_pkg::pos_t   major;
  smlm_pkg::pos_t   minor;
  logic             need_div;
  logic             div_start;
  logic             div_done;
  smlm_pkg::pos_t   div_quo;

  logic              emit;
  smlm_pkg::status_t e_status;
  logic              e_xs;
  logic              e_ys;
  logic              e_done;
  smlm_pkg::flags_t  e_fl;
  logic              e_pen;

  assign cfg_ready        = 1'b1;
  assign slot_free        = !m_tvalid || m_tready;
  assign take             = (state == S_IDLE) && !q_stat.empty && slot_free;
  assign q_pop            = take;
  assign is_tick          = (q_entry.kind == smlm_pkg::KIND_TICK);
  assign bk_stat.dividing = (state == S_DIV);
  assign bk_stat.moving   = busy;

  assign rc_inc   = ratio_count + 1'b1;
  assign hit      = (rc_inc == minor_ratio);
  assign major_en = flags.xmaj ? flags.xen : flags.yen;
  assign minor_en = hit && (flags.xmaj ? flags.yen : flags.xen);
  assign tick_xs  = flags.xmaj ? major_en : minor_en;
  assign tick_ys  = flags.xmaj ? minor_en : major_en;
  assign sl_dec   = steps_left - 1'b1;
  assign last     = (sl_dec == '0);

  assign pen_new  = (q_entry.kind != smlm_pkg::KIND_LINE);
  assign in_range = (q_entry.tx <= max_x) && (q_entry.ty <= max_y);

  always_comb begin
    n_fl.xen  = (q_entry.tx != position_x);
    n_fl.yen  = (q_entry.ty != position_y);
    n_fl.xdir = (q_entry.tx > position_x);
    n_fl.ydir = (q_entry.ty > position_y);
    dx = n_fl.xdir ? q_entry.tx - position_x : position_x - q_entry.tx;
    dy = n_fl.ydir ? q_entry.ty - position_y : position_y - q_entry.ty;
    n_fl.xmaj = (dx > dy);
    major = n_fl.xmaj ? dx : dy;
    minor = n_fl.xmaj ? dy : dx;
    need_div = (minor != '0);
  end

  assign div_start = take && !is_tick && !busy && in_range && need_div;

  smlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (major),
    .divisor  (minor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    emit     = 1'b0;
    e_status = smlm_pkg::ST_TICK;
    e_xs     = 1'b0;
    e_ys     = 1'b0;
    e_done   = 1'b0;
    e_fl     = flags;
    e_pen    = pen_up;
    if (take) begin
      emit = 1'b1;
      if (is_tick) begin
        if (busy) begin
          e_xs   = tick_xs;
          e_ys   = tick_ys;
          e_done = last;
        end
      end else if (busy) begin
        e_status = smlm_pkg::ST_BUSY;
      end else begin
        e_pen = pen_new;
        if (!in_range) begin
          e_status = smlm_pkg::ST_NACK;
        end else if (need_div) begin
          emit = 1'b0;
        end else begin
          e_status = smlm_pkg::ST_ACK;
          e_fl     = n_fl;
        end
      end
    end else if ((state == S_DIV) && div_done && slot_free) begin
      emit     = 1'b1;
      e_status = smlm_pkg::ST_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_x       <= '0;
      max_y       <= '0;
      position_x  <= '0;
      position_y  <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      steps_left  <= '0;
      minor_ratio <= '0;
      ratio_count <= '0;
      flags       <= '0;
      pen_up      <= 1'b1;
      busy        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == smlm_pkg::CFG_MAX_X) begin
          max_x <= cfg_data[smlm_pkg::PosBits-1:0];
        end else if (cfg_index == smlm_pkg::CFG_MAX_Y) begin
          max_y <= cfg_data[smlm_pkg::PosBits-1:0];
        end
      end

      if (emit) begin
        m_tvalid   <= 1'b1;
        out_status <= e_status;
        out_xs     <= e_xs;
        out_ys     <= e_ys;
        out_done   <= e_done;
        out_fl     <= e_fl;
        out_pen    <= e_pen;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (is_tick) begin
              if (busy) begin
                ratio_count <= hit ? '0 : rc_inc;
                steps_left  <= sl_dec;
                if (last) begin
                  position_x <= goal_x;
                  position_y <= goal_y;
                  busy       <= 1'b0;
                end
              end
            end else if (!busy) begin
              pen_up <= pen_new;
              if (in_range) begin
                flags       <= n_fl;
                ratio_count <= '0;
                minor_ratio <= '0;
                goal_x      <= q_entry.tx;
                goal_y      <= q_entry.ty;
                steps_left  <= major;
                if (major == '0) begin
                  position_x <= q_entry.tx;
                  position_y <= q_entry.ty;
                end else begin
                  busy <= 1'b1;
                end
                if (need_div) begin
                  state <= S_DIV;
                end
              end
            end
          end
        end
        S_DIV: begin
          if (div_done && slot_free) begin
            minor_ratio <= div_quo;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {2'b00, out_done, out_pen, out_fl.ydir, out_ys, out_fl.xdir, out_xs};

endmodule

// ===== tb/sv/tb_two_axis_stepper_line_mover_unit.sv =====
// Self-checking bench for two_axis_stepper_line_mover_unit: stream driver, response monitor,
// limit-register writes and a per-command predictor of the step sequencer.
// Depends on smlm_pkg and the RTL of the unit.
module tb_two_axis_stepper_line_mover_unit;
  import smlm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AFTER     = 60;

  typedef struct packed {
    status_t    status;
    logic [1:0] pad;
    logic       move_done;
    logic       pen_is_up;
    logic       y_dir;
    logic       y_step;
    logic       x_dir;
    logic       x_step;
  } response_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [InDataBits-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = KIND_TICK;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OutDataBits-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = CFG_MAX_X;
  logic [15:0]            cfg_data = '0;

  two_axis_stepper_line_mover_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted mover state
  pos_t   lim_x, lim_y;
  pos_t   pos_x, pos_y, goal_x, goal_y;
  pos_t   steps_left, ratio, ratio_cnt;
  flags_t flags;
  logic   pen_up, moving;

  // command planning for stimulus
  pos_t        plan_x, plan_y;
  int unsigned plan_left;

  cmd_t        cmds_to_send[$];
  response_t   responses_due[$];
  int unsigned cmds_issued, cmds_taken;
  int unsigned bad_reports;
  int unsigned in_gap, in_calm, out_gap, out_calm;
  int unsigned hold_left, quiet;
  logic        hold_armed;
  cmd_t        cur_cmd;
  response_t   got, want;

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 60);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic response_t predict_response(cmd_t c);
    response_t r;
    flags_t    fl;
    pos_t      dx, dy;
    logic      minor, major_en;
    r = '0;
    r.status = ST_TICK;
    if (c.kind == KIND_TICK) begin
      if (moving) begin
        major_en = flags.xmaj ? flags.xen : flags.yen;
        minor = 1'b0;
        ratio_cnt = ratio_cnt + 1'b1;
        if (ratio_cnt == ratio) begin
          ratio_cnt = '0;
          minor = flags.xmaj ? flags.yen : flags.xen;
        end
        r.x_step = flags.xmaj ? major_en : minor;
        r.y_step = flags.xmaj ? minor : major_en;
        steps_left = steps_left - 1'b1;
        if (steps_left == 0) begin
          pos_x = goal_x;
          pos_y = goal_y;
          moving = 1'b0;
          r.move_done = 1'b1;
        end
      end
    end else if (moving) begin
      r.status = ST_BUSY;
    end else begin
      // pen follows the command even when the target is refused
      pen_up = (c.kind != KIND_LINE);
      if (c.kind == KIND_FINISH) begin
        c.tx = '0;
        c.ty = '0;
      end
      if (c.tx > lim_x || c.ty > lim_y) begin
        r.status = ST_NACK;
      end else begin
        r.status = ST_ACK;
        fl = '0;
        fl.xen = (c.tx != pos_x);
        fl.yen = (c.ty != pos_y);
        fl.xdir = (c.tx > pos_x);
        fl.ydir = (c.ty > pos_y);
        dx = fl.xdir ? c.tx - pos_x : pos_x - c.tx;
        dy = fl.ydir ? c.ty - pos_y : pos_y - c.ty;
        ratio = '0;
        if (dx > dy) begin
          fl.xmaj = 1'b1;
          steps_left = dx;
          if (fl.yen && dy != 0) ratio = dx / dy;
        end else begin
          steps_left = dy;
          if (fl.xen && dx != 0) ratio = dy / dx;
        end
        flags = fl;
        ratio_cnt = '0;
        goal_x = c.tx;
        goal_y = c.ty;
        if (steps_left == 0) begin
          pos_x = goal_x;
          pos_y = goal_y;
          moving = 1'b0;
        end else begin
          moving = 1'b1;
        end
      end
    end
    r.x_dir = flags.xdir;
    r.y_dir = flags.ydir;
    r.pen_is_up = pen_up;
    return r;
  endfunction

  function automatic string show(response_t r);
    return $sformatf("status=%0d x_step=%0b x_dir=%0b y_step=%0b y_dir=%0b pen=%0b done=%0b pad=%0b",
                     r.status, r.x_step, r.x_dir, r.y_step, r.y_dir, r.pen_is_up,
                     r.move_done, r.pad);
  endfunction

  function automatic pos_t near_coord(pos_t cur, pos_t lim);
    int v;
    v = int'(cur) + int'($urandom_range(0, 32)) - 16;
    if (v < 0) v = 0;
    if (v > int'(lim)) v = int'(lim);
    return pos_t'(v);
  endfunction

  task automatic issue(kind_t k, pos_t tx, pos_t ty);
    pos_t ex, ey, dx, dy;
    cmds_to_send.push_back(cmd_t'{kind: k, tx: tx, ty: ty});
    cmds_issued++;
    if (k == KIND_TICK) begin
      if (plan_left != 0) plan_left--;
    end else if (plan_left == 0) begin
      ex = (k == KIND_FINISH) ? pos_t'(0) : tx;
      ey = (k == KIND_FINISH) ? pos_t'(0) : ty;
      if (ex <= lim_x && ey <= lim_y) begin
        dx = (ex > plan_x) ? ex - plan_x : plan_x - ex;
        dy = (ey > plan_y) ? ey - plan_y : plan_y - ey;
        plan_left = (dx > dy) ? dx : dy;
        plan_x = ex;
        plan_y = ey;
      end
    end
  endtask

  task automatic tick();
    issue(KIND_TICK, pos_t'($urandom), pos_t'($urandom));
  endtask

  task automatic wait_drained();
    while (cmds_taken != cmds_issued || responses_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_limits(pos_t x, pos_t y);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_X;
    cfg_data  <= x;
    do @(posedge clk); while (!cfg_ready);
    lim_x = x;
    cfg_index <= CFG_MAX_Y;
    cfg_data  <= y;
    do @(posedge clk); while (!cfg_ready);
    lim_y = y;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    int unsigned first, r;
    kind_t       k;
    pos_t        tx, ty;
    first = cmds_issued;
    while (cmds_issued - first < n || plan_left != 0) begin
      r  = $urandom_range(0, 99);
      k  = kind_t'($urandom_range(1, 3));
      tx = pos_t'($urandom);
      ty = pos_t'($urandom);
      if (cmds_issued - first >= n) begin
        tick();
      end else if (plan_left != 0) begin
        if (r < 88) tick();
        else issue(k, tx, ty);
      end else if (r < 10) begin
        tick();
      end else if (r < 25 && (k == KIND_FINISH || tx > lim_x || ty > lim_y)) begin
        issue(k, tx, ty);
      end else begin
        issue(k, near_coord(plan_x, lim_x), near_coord(plan_y, lim_y));
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        responses_due.push_back(predict_response(cur_cmd));
        cmds_taken++;
        in_gap = pick_gap(in_calm);
      end
      if (!s_tvalid || s_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (cmds_to_send.size() != 0) begin
          cur_cmd = cmds_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_cmd.ty, cur_cmd.tx};
          s_tuser  <= cur_cmd.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // hold off the receiver once so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && cmds_taken >= HOLD_AFTER) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = response_t'({m_tuser, m_tdata});
        if (responses_due.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10) $display("unexpected response beat: %s", show(got));
        end else begin
          want = responses_due.pop_front();
          if (got !== want) begin
            bad_reports++;
            if (bad_reports <= 10)
              $display("response mismatch\n  expected %s\n  actual   %s", show(want), show(got));
          end
        end
        out_gap = pick_gap(out_calm);
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    lim_x = '0;
    lim_y = '0;
    pos_x = '0;
    pos_y = '0;
    goal_x = '0;
    goal_y = '0;
    steps_left = '0;
    ratio = '0;
    ratio_cnt = '0;
    flags = '0;
    pen_up = 1'b1;
    moving = 1'b0;
    plan_x = '0;
    plan_y = '0;
    plan_left = 0;
    cmds_issued = 0;
    cmds_taken = 0;
    bad_reports = 0;
    in_gap = 0;
    in_calm = 0;
    out_gap = 0;
    out_calm = 0;
    quiet = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limits: only the origin is reachable
    issue(KIND_TICK, 16'hFFFF, 16'h0000);
    issue(KIND_MOVE, 16'h0000, 16'h0000);
    issue(KIND_LINE, 16'h0001, 16'h0000);
    issue(KIND_LINE, 16'hFFFF, 16'hFFFF);
    issue(KIND_FINISH, 16'hFFFF, 16'hFFFF);
    wait_drained();

    write_limits(16'd4, 16'd3);
    issue(KIND_LINE, 16'd4, 16'd1);
    tick();
    tick();
    issue(KIND_MOVE, 16'hFFFF, 16'hFFFF);
    tick();
    tick();
    issue(KIND_MOVE, 16'd4, 16'd3);
    tick();
    tick();
    issue(KIND_LINE, 16'd2, 16'd1);
    tick();
    tick();
    issue(KIND_LINE, 16'd5, 16'd0);
    issue(KIND_LINE, 16'd0, 16'd4);
    issue(KIND_FINISH, 16'd3, 16'd3);
    tick();
    tick();
    issue(KIND_TICK, 16'h0000, 16'hFFFF);
    wait_drained();

    write_limits(16'd40, 16'd25);
    run_random(110);
    wait_drained();

    write_limits(16'd0, 16'hFFFF);
    run_random(90);
    wait_drained();

    write_limits(16'hFFFF, 16'd0);
    run_random(90);
    wait_drained();

    write_limits(16'hFFFF, 16'hFFFF);
    run_random(80);
    // long line with a large ratio
    issue(KIND_LINE, plan_x + 16'd128, plan_y + 16'd2);
    tick();
    issue(KIND_FINISH, 16'h0000, 16'h0000);
    while (plan_left != 0) tick();
    tick();
    wait_drained();

    repeat (40) @(posedge clk);
    if (bad_reports == 0 && responses_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/smlm_pkg.sv
rtl/core/smlm_front.sv
rtl/core/smlm_queue.sv
rtl/core/smlm_div.sv
rtl/core/smlm_back.sv
rtl/core/two_axis_stepper_line_mover_unit.sv
tb/sv/tb_two_axis_stepper_line_mover_unit.sv
